### hw/rtl/xpw_pkg.sv
// Shared constants and types of the XNOR-popcount window accumulator.
package xpw_pkg;

    localparam int WORD_BITS = 64;
    localparam int POP_W     = 7;
    localparam int REM_W     = 6;
    localparam int COUNT_W   = 19;
    localparam int DOT_W     = 20;
    localparam int COUNT_HW_MAX = 524287;

    // Per-word contribution handed from the popcount stage to the accumulator.
    typedef struct packed {
        logic [POP_W-1:0] match_bits;
        logic [POP_W-1:0] nbits;
        logic             eow;
    } tap_count_t;

endpackage

### hw/rtl/xpw_front.sv
// Input register plus masked XNOR popcount stage.
module xpw_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [xpw_pkg::REM_W-1:0]    channel_remainder,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [xpw_pkg::WORD_BITS-1:0] act_word,
    input  logic [xpw_pkg::WORD_BITS-1:0] weight_word,
    input  logic                         last_word_of_tap,
    input  logic                         end_of_window,
    output logic                         cnt_valid,
    input  logic                         cnt_ready,
    output xpw_pkg::tap_count_t          cnt
);

    // Adder tree, one level per loop; each loop runs over independent pairs.
    function automatic logic [xpw_pkg::POP_W-1:0] popcount64(
        input logic [xpw_pkg::WORD_BITS-1:0] x);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++)
        begin
            l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

    logic                          s1_valid_reg;
    logic [xpw_pkg::WORD_BITS-1:0] s1_act_reg;
    logic [xpw_pkg::WORD_BITS-1:0] s1_wgt_reg;
    logic                          s1_last_reg;
    logic                          s1_eow_reg;
    logic                          s2_valid_reg;
    xpw_pkg::tap_count_t           s2_cnt_reg;
    xpw_pkg::tap_count_t           s2_cnt_next;
    logic [xpw_pkg::WORD_BITS-1:0] mask;
    logic                          s1_move;
    logic                          in_fire;

    assign s1_move  = s1_valid_reg && (!s2_valid_reg || cnt_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        mask              = '1;
        s2_cnt_next.nbits = xpw_pkg::POP_W'(xpw_pkg::WORD_BITS);
        if (s1_last_reg && (channel_remainder != '0))
        begin
            mask              = (xpw_pkg::WORD_BITS'(1) << channel_remainder)
                                - xpw_pkg::WORD_BITS'(1);
            s2_cnt_next.nbits = {1'b0, channel_remainder};
        end
        s2_cnt_next.match_bits = popcount64(~(s1_act_reg ^ s1_wgt_reg) & mask);
        s2_cnt_next.eow        = s1_eow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                s2_valid_reg <= 1'b1;
            else if (cnt_ready)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_act_reg  <= act_word;
            s1_wgt_reg  <= weight_word;
            s1_last_reg <= last_word_of_tap;
            s1_eow_reg  <= end_of_window;
        end
        if (s1_move)
            s2_cnt_reg <= s2_cnt_next;
    end

    assign cnt_valid = s2_valid_reg;
    assign cnt       = s2_cnt_reg;

endmodule

### hw/rtl/xpw_accum.sv
// Saturating window counters and the registered result stage.
module xpw_accum #(
    parameter int MAX_WINDOW_WORDS = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cnt_valid,
    output logic                          cnt_ready,
    input  xpw_pkg::tap_count_t           cnt,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [xpw_pkg::DOT_W-1:0]     dot_value,
    output logic                          overflow
);

    localparam int LIM_RAW   = MAX_WINDOW_WORDS * xpw_pkg::WORD_BITS;
    localparam int COUNT_MAX = (LIM_RAW > xpw_pkg::COUNT_HW_MAX) ?
                               xpw_pkg::COUNT_HW_MAX : LIM_RAW;
    localparam logic [xpw_pkg::COUNT_W:0] COUNT_MAX_W = (xpw_pkg::COUNT_W+1)'(COUNT_MAX);

    logic [xpw_pkg::COUNT_W-1:0] match_reg, match_next;
    logic [xpw_pkg::COUNT_W-1:0] bit_reg, bit_next;
    logic                        sat_reg;
    logic [xpw_pkg::COUNT_W:0]   match_sum, bit_sum;
    logic                        sat_m, sat_b;
    logic                        out_valid_reg;
    logic [xpw_pkg::DOT_W-1:0]   dot_reg, dot_next;
    logic                        ovf_reg;
    logic                        out_free;
    logic                        cnt_fire;
    logic                        emit;

    assign out_free  = !out_valid_reg || out_ready;
    // Only a window-closing word needs room in the result register.
    assign cnt_ready = !cnt.eow || out_free;
    assign cnt_fire  = cnt_valid && cnt_ready;
    assign emit      = cnt_fire && cnt.eow;

    always_comb
    begin
        match_sum = {1'b0, match_reg} + (xpw_pkg::COUNT_W+1)'(cnt.match_bits);
        bit_sum   = {1'b0, bit_reg} + (xpw_pkg::COUNT_W+1)'(cnt.nbits);
        sat_m     = match_sum > COUNT_MAX_W;
        sat_b     = bit_sum > COUNT_MAX_W;
        match_next = sat_m ? COUNT_MAX_W[xpw_pkg::COUNT_W-1:0]
                           : match_sum[xpw_pkg::COUNT_W-1:0];
        bit_next   = sat_b ? COUNT_MAX_W[xpw_pkg::COUNT_W-1:0]
                           : bit_sum[xpw_pkg::COUNT_W-1:0];
        dot_next   = {match_next, 1'b0} - {1'b0, bit_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= '0;
            bit_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cnt_fire)
            begin
                if (cnt.eow)
                begin
                    match_reg <= '0;
                    bit_reg   <= '0;
                    sat_reg   <= 1'b0;
                end
                else
                begin
                    match_reg <= match_next;
                    bit_reg   <= bit_next;
                    sat_reg   <= sat_reg || sat_m || sat_b;
                end
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            dot_reg <= dot_next;
            ovf_reg <= sat_reg || sat_m || sat_b;
        end
    end

    assign out_valid = out_valid_reg;
    assign dot_value = dot_reg;
    assign overflow  = ovf_reg;

    a_match_le_bits: assert property (@(posedge clk) disable iff (!rst_n)
        match_reg <= bit_reg)
        else $error("match count above bit count");

    a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, bit_reg} <= COUNT_MAX_W)
        else $error("bit count past its bound");

    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (match_reg == '0) && (bit_reg == '0) && !sat_reg)
        else $error("window state not cleared after result");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("result lost at window end");

endmodule

### hw/rtl/xnor_popcount_window_accumulator.sv
// Top level of the XNOR-popcount window accumulator (binary dot product).
//
// One transfer per cycle is accepted on the slave side unless s_tready is
// held low by a stall: tdata carries the activation word (bits 63:0) and the
// weight word (bits 127:64), tuser flags the last word of a kernel tap and
// tlast closes an output window. Each word passes an input register, then a
// masked XNOR popcount stage, then the saturating counters; the closing word
// of a window loads the result register. Words follow back to back at one per
// cycle while nothing stalls. A result register parts the two sides; only a
// window-closing word waits for it to drain, other words keep flowing while a
// result is held. dot_value = 2*matches - bits over the window, both counts
// saturating at min(MAX_WINDOW_WORDS*64, 524287) with overflow flagging that.
// The channel_remainder register (cfg_we/cfg_data) limits the last word of a
// tap to its low bits; write it only while no transfer is in flight.
module xnor_popcount_window_accumulator #(
    parameter int MAX_WINDOW_WORDS = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // slave stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [127:0]              s_tdata,   // act_word, weight_word
    input  logic                      s_tuser,   // last_word_of_tap
    input  logic                      s_tlast,   // end_of_window
    // master stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // dot_value (19:0), zero pad
    output logic                      m_tuser,   // overflow
    // configuration
    input  logic                      cfg_we,
    input  logic [xpw_pkg::REM_W-1:0] cfg_data   // channel_remainder
);

    logic [xpw_pkg::REM_W-1:0] channel_remainder_reg;
    logic                      cnt_valid;
    logic                      cnt_ready;
    xpw_pkg::tap_count_t       cnt;
    logic [xpw_pkg::DOT_W-1:0] dot_value;

    // Channel-remainder register; no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            channel_remainder_reg <= '0;
        else if (cfg_we)
            channel_remainder_reg <= cfg_data;
    end

    // Input register and popcount of the masked XNOR.
    xpw_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .channel_remainder (channel_remainder_reg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .act_word          (s_tdata[63:0]),
        .weight_word       (s_tdata[127:64]),
        .last_word_of_tap  (s_tuser),
        .end_of_window     (s_tlast),
        .cnt_valid         (cnt_valid),
        .cnt_ready         (cnt_ready),
        .cnt               (cnt)
    );

    // Window counters and the result register.
    xpw_accum #(
        .MAX_WINDOW_WORDS (MAX_WINDOW_WORDS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cnt_valid (cnt_valid),
        .cnt_ready (cnt_ready),
        .cnt       (cnt),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dot_value (dot_value),
        .overflow  (m_tuser)
    );

    assign m_tdata = {4'b0000, dot_value};

endmodule

### verif/xnor_popcount_window_accumulator_checker.sv
// Stream monitor and result predictor for the XNOR-popcount window accumulator.
module xnor_popcount_window_accumulator_checker #(
    parameter int MAX_WINDOW_WORDS = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [127:0]              s_tdata,   // act_word (63:0), weight_word (127:64)
    input  logic                      s_tuser,   // last_word_of_tap
    input  logic                      s_tlast,   // end_of_window
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [23:0]               m_tdata,   // dot_value (19:0), zero pad
    input  logic                      m_tuser,   // overflow
    input  logic                      cfg_we,
    input  logic [xpw_pkg::REM_W-1:0] cfg_data,  // channel_remainder
    output int                        mismatch_count,
    output int                        windows_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_COUNT  = MAX_WINDOW_WORDS * xpw_pkg::WORD_BITS;
    localparam int COUNT_LIMIT = (FULL_COUNT > xpw_pkg::COUNT_HW_MAX) ?
                                 xpw_pkg::COUNT_HW_MAX : FULL_COUNT;

    typedef struct packed {
        logic [xpw_pkg::DOT_W-1:0] dot_value;
        logic                      overflow;
    } window_result_t;

    window_result_t            window_results_due[$];
    logic [xpw_pkg::REM_W-1:0] channel_remainder;
    int                        match_total;
    int                        bit_total;
    logic                      window_saturated;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // One accepted word: masked xnor popcount into saturating window counts.
    task automatic accumulate_word(input logic [xpw_pkg::WORD_BITS-1:0] act,
                                   input logic [xpw_pkg::WORD_BITS-1:0] wgt,
                                   input logic tap_end, input logic win_end);
        logic [xpw_pkg::WORD_BITS-1:0] valid_mask;
        int                            valid_bits;
        window_result_t                res;
        valid_mask = '1;
        valid_bits = xpw_pkg::WORD_BITS;
        if (tap_end && channel_remainder != '0)
        begin
            valid_mask = (64'd1 << channel_remainder) - 64'd1;
            valid_bits = int'(channel_remainder);
        end
        match_total += $countones(~(act ^ wgt) & valid_mask);
        if (match_total > COUNT_LIMIT)
        begin
            match_total      = COUNT_LIMIT;
            window_saturated = 1'b1;
        end
        bit_total += valid_bits;
        if (bit_total > COUNT_LIMIT)
        begin
            bit_total        = COUNT_LIMIT;
            window_saturated = 1'b1;
        end
        if (win_end)
        begin
            res.dot_value = xpw_pkg::DOT_W'(2 * match_total - bit_total);
            res.overflow  = window_saturated;
            window_results_due.push_back(res);
            match_total      = 0;
            bit_total        = 0;
            window_saturated = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        window_result_t want;
        if (!rst_n)
        begin
            window_results_due.delete();
            channel_remainder = '0;
            match_total       = 0;
            bit_total         = 0;
            window_saturated  = 1'b0;
            mismatch_count    = 0;
            windows_pending   = 0;
        end
        else
        begin
            if (cfg_we)
                channel_remainder = cfg_data;
            // a result never leaves in the cycle its closing word enters,
            // so compare before predicting
            if (m_tvalid && m_tready)
            begin
                if (window_results_due.size() == 0)
                begin
                    report_mismatch("window result with none due",
                                    int'($signed(m_tdata[xpw_pkg::DOT_W-1:0])), 0);
                end
                else
                begin
                    want = window_results_due.pop_front();
                    if (m_tdata[xpw_pkg::DOT_W-1:0] !== want.dot_value)
                        report_mismatch("dot_value",
                                        int'($signed(m_tdata[xpw_pkg::DOT_W-1:0])),
                                        int'($signed(want.dot_value)));
                    if (m_tuser !== want.overflow)
                        report_mismatch("overflow", int'(m_tuser), int'(want.overflow));
                end
            end
            if (s_tvalid && s_tready)
                accumulate_word(s_tdata[63:0], s_tdata[127:64], s_tuser, s_tlast);
            windows_pending = window_results_due.size();
        end
    end

endmodule

### verif/xnor_popcount_window_accumulator_tb.sv
// Testbench top for the XNOR-popcount window accumulator: stimulus, flow control, verdict.
module xnor_popcount_window_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_WINDOW_WORDS = 4096;
    localparam time CLK_PERIOD       = 10ns;
    localparam int  RESET_CYCLES     = 11;
    // three stages from input to result register; leave some margin
    localparam int  PIPE_DRAIN       = 8;
    localparam int  RX_HOLD_CYCLES   = 200;
    localparam int  IDLE_LIMIT       = 3000;
    localparam int  RANDOM_ITEMS     = 1500;
    localparam int  RANDOM_PHASES    = 8;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [127:0]              s_tdata = '0;   // act_word (63:0), weight_word (127:64)
    logic                      s_tuser = 1'b0; // last_word_of_tap
    logic                      s_tlast = 1'b0; // end_of_window
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [23:0]               m_tdata;        // dot_value (19:0), zero pad
    logic                      m_tuser;        // overflow
    logic                      cfg_we = 1'b0;
    logic [xpw_pkg::REM_W-1:0] cfg_data = '0;  // channel_remainder

    int   mismatch_count;
    int   windows_pending;
    int   idle_cycles = 0;
    logic sender_burst = 1'b0;   // no gaps between source transfers
    logic receiver_burst = 1'b0; // sink always ready
    logic rx_hold_req = 1'b0;    // ask the sink for one long hold-off

    always #(CLK_PERIOD / 2) clk = ~clk;

    xnor_popcount_window_accumulator #(
        .MAX_WINDOW_WORDS(MAX_WINDOW_WORDS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    xnor_popcount_window_accumulator_checker #(
        .MAX_WINDOW_WORDS(MAX_WINDOW_WORDS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .windows_pending (windows_pending)
    );

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("xnor_popcount_window_accumulator_tb failed");
            $finish;
        end
    end

    // Sink: random hold-off per result, burst stretches, and one long hold
    // on request so the result register backs up into the source side.
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    receiver_burst = ~receiver_burst;
                gap = receiver_burst ? 0 : $urandom_range(0, 9);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Weight biased toward full match, full mismatch and single-bit flips
    // so window values spread to both ends.
    function automatic logic [63:0] pick_weight(input logic [63:0] act);
        case ($urandom_range(0, 9))
            0:       return act;
            1:       return ~act;
            2:       return act ^ (64'd1 << $urandom_range(0, 63));
            default: return rand_word();
        endcase
    endfunction

    // One source transfer; entered anywhere after a rising edge, returns
    // right after the edge that took the word. tvalid stays up on return.
    task automatic send_word(input logic [63:0] act, input logic [63:0] wgt,
                             input logic tap_end, input logic win_end);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wgt, act};
        s_tuser  <= tap_end;
        s_tlast  <= win_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering, wait for every window result, then let the words that
    // carry no result leave the pipeline too.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (windows_pending != 0)
            @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic set_remainder(input logic [xpw_pkg::REM_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // A window of random taps (1 to 3 words each), with the odd stray or
    // missing last-of-tap flag; only the final word closes the window.
    task automatic send_window(input int words);
        int          tap_left;
        logic        tap_end;
        logic [63:0] act;
        tap_left = $urandom_range(1, 3);
        for (int i = 0; i < words; i++)
        begin
            tap_left--;
            tap_end = (tap_left == 0);
            if (tap_end)
                tap_left = $urandom_range(1, 3);
            if ($urandom_range(0, 15) == 0)
                tap_end = ~tap_end;
            case ($urandom_range(0, 15))
                0:       act = '0;
                1:       act = '1;
                default: act = rand_word();
            endcase
            send_word(act, pick_weight(act), tap_end, i == words - 1);
        end
    endtask

    initial
    begin : stimulus
        int phase_items;
        int words;
        logic [xpw_pkg::REM_W-1:0] remainder;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed, channel_remainder at its reset value (full words) ----
        send_word('0, '0, 1'b0, 1'b1);                        // +64
        send_word('1, '0, 1'b0, 1'b1);                        // -64
        send_word('1, '1, 1'b1, 1'b1);                        // full last word: +64
        send_word({32{2'b01}}, {32{2'b10}}, 1'b1, 1'b1);      // -64
        send_word(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0);
        send_word('1, '0, 1'b0, 1'b0);
        send_word(rand_word(), rand_word(), 1'b1, 1'b1);      // three-word window

        // ---- widest remainder: bit 63 of the last word is dropped ----
        set_remainder(6'd63);
        send_word('1, '1, 1'b1, 1'b1);                        // +63
        send_word('1, ~(64'd1 << 63), 1'b1, 1'b1);            // masked flip: +63
        send_word('1, ~(64'd1 << 63), 1'b0, 1'b1);            // unmasked: +62
        send_word('0, '1, 1'b0, 1'b0);
        send_word('0, '1, 1'b1, 1'b1);                        // -127

        // ---- narrowest remainder: only bit 0 counts on the last word ----
        set_remainder(6'd1);
        send_word('0, 64'd1, 1'b1, 1'b1);                     // -1
        send_word(64'd2, '0, 1'b1, 1'b1);                     // +1
        send_word(rand_word(), rand_word(), 1'b0, 1'b0);
        send_word('1, '0, 1'b1, 1'b1);

        // ---- random phases, one remainder each, both extremes included ----
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       remainder = 6'd0;
                1:       remainder = 6'd63;
                2:       remainder = 6'd1;
                default: remainder = xpw_pkg::REM_W'($urandom_range(0, 63));
            endcase
            set_remainder(remainder);

            if (phase == 1)
            begin
                // sink holds off while single-word windows keep coming at
                // full rate: the result register fills and the source stalls
                rx_hold_req  = 1'b1;
                sender_burst = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_word(rand_word(), rand_word(), 1'($urandom_range(0, 1)), 1'b1);
                sender_burst = 1'b0;
            end

            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / RANDOM_PHASES)
            begin
                words = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                sender_burst = ($urandom_range(0, 4) == 0);
                send_window(words);
                phase_items += words;
            end
            sender_burst = 1'b0;
        end

        wait_drained();
        if (mismatch_count == 0 && windows_pending == 0)
            $display("xnor_popcount_window_accumulator_tb passed");
        else
            $display("xnor_popcount_window_accumulator_tb failed");
        $finish;
    end

endmodule
